[rtl/core/crs_pkg.sv]
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the click rate smoothing unit
// Opcodes, fixed-point constants, pipeline depths and the sideband record
// that travels with every request through the arithmetic units.
// ----------------------------------------------------------------------------
package crs_pkg;

  // formula select
  typedef enum logic [1:0] {
    OP_PLAIN  = 2'd0,
    OP_CONF   = 2'd1,
    OP_DAMPED = 2'd2,
    OP_BLEND  = 2'd3
  } op_t;

  // fixed-point constants
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [31:0] W_FULL_SHOWS = 32'd6144;
  localparam logic [31:0] DAMP_KNEE    = 32'd2560;
  localparam logic [23:0] OUT_MAX      = 24'hFF_FFFF;
  localparam logic [16:0] Q16_ONE      = 17'h1_0000;
  localparam logic [40:0] R_CLAMP      = 41'h100_0000_0000;

  // pipeline depths
  localparam int unsigned DIV_QW    = 48;
  localparam int unsigned EXP_TERMS = 12;
  localparam int unsigned SQ_STEPS  = 5;

  // per-request sideband carried through the long units
  typedef struct packed {
    op_t         op;
    logic        zero_s;
    logic        zero_d;
    logic        s_big;
    logic        low_m;
    logic        n_big;
    logic [4:0]  n_sh;
    logic [31:0] arg;
    logic [47:0] ratio;
  } side_t;

endpackage

[rtl/core/crs_if.sv]
// ----------------------------------------------------------------------------
// crs_if: request and result channels
// Valid/ready channels carrying the counter request and the smoothed rate.
// ----------------------------------------------------------------------------
interface crs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] shows_count;
  logic [31:0] clicks_count;
  logic [1:0]  opcode;

  modport source (output valid, shows_count, clicks_count, opcode, input ready);
  modport sink   (input valid, shows_count, clicks_count, opcode, output ready);
endinterface

interface crs_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rate_value;
  logic        saturated;

  modport source (output valid, rate_value, saturated, input ready);
  modport sink   (input valid, rate_value, saturated, output ready);
endinterface

[rtl/core/click_rate_smoothing_unit.sv]
// ----------------------------------------------------------------------------
// click_rate_smoothing_unit: smoothed click rate from two counters
// Deep pipeline: ratio divider, shared e^-y series, squaring, a second
// divider for the weight or damping factor, then combine and saturate.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request: shows_count and clicks_count (UQ24.8) and an
//   opcode; it is taken when valid and ready are both high.
//   out_chan returns one result per request, in order: rate_value (UQ8.16)
//   and saturated, set when the result was clamped to the top of the range.
//   On its way to out_chan.valid a request passes the two 48-stage
//   dividers, the 36-stage series unit, five squaring stages and two
//   combine stages.
//   Throughput is one request per cycle while the output is not stalled.
//   All stages advance together while the output register is empty or is
//   being taken; when the receiver holds ready low with a result waiting,
//   the whole pipeline holds and in_chan.ready drops, nothing is lost.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the data
//   registers are not reset.
// ----------------------------------------------------------------------------
module click_rate_smoothing_unit (
  input  logic      clk,
  input  logic      rst_n,
  crs_in_if.sink    in_chan,
  crs_out_if.source out_chan
);

  localparam int unsigned NSQ = crs_pkg::SQ_STEPS;

  logic        adv;
  logic        out_valid_r;
  logic [23:0] out_rate_r;
  logic        out_sat_r;

  // whole pipeline moves unless a result is stuck at the output
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // request decode
  logic [31:0]    s_in;
  logic [31:0]    c_in;
  logic [31:0]    m_in;
  logic           low_m_in;
  logic [31:0]    a_in;
  logic [39:0]    g_mul;
  crs_pkg::side_t side_in;

  assign s_in     = in_chan.shows_count;
  assign c_in     = in_chan.clicks_count;
  assign m_in     = (c_in < s_in) ? c_in : s_in;
  assign low_m_in = m_in <= crs_pkg::DAMP_KNEE;
  assign a_in     = low_m_in ? crs_pkg::DAMP_KNEE - m_in : m_in - crs_pkg::DAMP_KNEE;
  assign g_mul    = 40'(a_in[7:0]) * 40'(crs_pkg::LN2_Q32);

  always_comb begin
    side_in.op     = crs_pkg::op_t'(in_chan.opcode);
    side_in.zero_s = s_in == '0;
    side_in.zero_d = (s_in == '0) || (c_in == '0);
    side_in.s_big  = s_in >= crs_pkg::W_FULL_SHOWS;
    side_in.low_m  = low_m_in;
    side_in.n_big  = |a_in[31:13];
    side_in.n_sh   = a_in[12:8];
    side_in.arg    = (side_in.op == crs_pkg::OP_DAMPED) ? g_mul[39:8] : {s_in[12:0], 19'b0};
    side_in.ratio  = '0;
  end

  // clicks / shows
  logic           ra_valid;
  logic [47:0]    ra_quot;
  crs_pkg::side_t ra_side;
  crs_pkg::side_t ex_side_in;

  crs_divider u_div_ratio (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (in_chan.valid),
    .in_dividend ({16'b0, c_in, 16'b0}),
    .in_divisor  ({2'b0, s_in}),
    .in_side     (side_in),
    .out_valid   (ra_valid),
    .out_quot    (ra_quot),
    .out_side    (ra_side)
  );

  always_comb begin
    ex_side_in       = ra_side;
    ex_side_in.ratio = ra_side.zero_s ? '0 : ra_quot;
  end

  // shared e^-y series
  logic           ex_valid;
  logic [32:0]    ex_val;
  crs_pkg::side_t ex_side;

  crs_expneg u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (ra_valid),
    .in_arg    (ex_side_in.arg),
    .in_side   (ex_side_in),
    .out_valid (ex_valid),
    .out_val   (ex_val),
    .out_side  (ex_side)
  );

  // repeated squaring for the weight formulas
  logic           sq_v_r    [NSQ];
  logic [32:0]    sq_e_r    [NSQ];
  crs_pkg::side_t sq_side_r [NSQ];

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    logic           pv;
    logic [32:0]    pe;
    crs_pkg::side_t pside;
    logic [31:0]    ec;
    logic [63:0]    sq;
    logic           is_w;

    if (g == 0) begin : g_first
      assign pv    = ex_valid;
      assign pe    = ex_val;
      assign pside = ex_side;
    end else begin : g_next
      assign pv    = sq_v_r[g-1];
      assign pe    = sq_e_r[g-1];
      assign pside = sq_side_r[g-1];
    end

    assign is_w = (pside.op == crs_pkg::OP_CONF) || (pside.op == crs_pkg::OP_BLEND);
    assign ec   = pe[32] ? 32'hFFFF_FFFF : pe[31:0];
    assign sq   = 64'(ec) * 64'(ec);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[g] <= 1'b0;
      end else if (adv) begin
        sq_v_r[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_e_r[g]    <= is_w ? {1'b0, sq[63:32]} : pe;
        sq_side_r[g] <= pside;
      end
    end
  end

  // operands of the weight or damping division
  crs_pkg::side_t pr_side;
  logic [32:0]    pr_e;
  logic [32:0]    pr_p;
  logic [63:0]    pr_num;
  logic [33:0]    pr_den;

  assign pr_side = sq_side_r[NSQ-1];
  assign pr_e    = sq_e_r[NSQ-1];
  assign pr_p    = pr_side.n_big ? '0 : pr_e >> pr_side.n_sh;

  always_comb begin
    if ((pr_side.op == crs_pkg::OP_CONF) || (pr_side.op == crs_pkg::OP_BLEND)) begin
      pr_num = 64'(crs_pkg::ONE_Q32 - pr_e) << 16;
      pr_den = 34'(crs_pkg::ONE_Q32) + 34'(pr_e);
    end else if (pr_side.low_m) begin
      pr_num = 64'(pr_p) << 30;
      pr_den = 34'(pr_p) + 34'(crs_pkg::ONE_Q32);
    end else begin
      pr_num = 64'h4000_0000_0000_0000;
      pr_den = 34'(crs_pkg::ONE_Q32) + 34'(pr_p);
    end
  end

  logic           fb_valid;
  logic [47:0]    fb_quot;
  crs_pkg::side_t fb_side;

  crs_divider u_div_frac (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (sq_v_r[NSQ-1]),
    .in_dividend (pr_num),
    .in_divisor  (pr_den),
    .in_side     (pr_side),
    .out_valid   (fb_valid),
    .out_quot    (fb_quot),
    .out_side    (fb_side)
  );

  // products of the combine step
  logic [16:0]    w_val;
  logic [16:0]    frac;
  logic [40:0]    r_clamp;
  logic           f1_v_r;
  crs_pkg::side_t f1_side_r;
  logic [16:0]    f1_w_r;
  logic [47:0]    f1_p2_r;
  logic [57:0]    f1_p3_r;

  assign w_val   = fb_side.s_big ? crs_pkg::Q16_ONE : fb_quot[16:0];
  assign frac    = (fb_side.ratio > 48'(crs_pkg::Q16_ONE)) ? crs_pkg::Q16_ONE
                                                         : fb_side.ratio[16:0];
  assign r_clamp = (fb_side.ratio > 48'(crs_pkg::R_CLAMP)) ? crs_pkg::R_CLAMP
                                                         : fb_side.ratio[40:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= fb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_side_r <= fb_side;
      f1_w_r    <= w_val;
      f1_p2_r   <= 48'(frac) * 48'(fb_quot[30:0]);
      f1_p3_r   <= 58'(r_clamp) * 58'(w_val);
    end
  end

  // formula select and saturation
  logic [57:0] v_nxt;
  logic [16:0] w_rest;
  logic [48:0] conf_sum;
  logic [57:0] blend_sum;

  assign w_rest    = crs_pkg::Q16_ONE - f1_w_r;
  assign conf_sum  = 49'(w_rest) + 49'(f1_side_r.ratio);
  assign blend_sum = (58'(w_rest) << 15) + f1_p3_r;

  always_comb begin
    case (f1_side_r.op)
      crs_pkg::OP_PLAIN:  v_nxt = 58'(f1_side_r.ratio);
      crs_pkg::OP_CONF:   v_nxt = 58'(conf_sum >> 1);
      crs_pkg::OP_DAMPED: v_nxt = f1_side_r.zero_d ? '0 : 58'(f1_p2_r >> 30);
      crs_pkg::OP_BLEND:  v_nxt = blend_sum >> 16;
      default:            v_nxt = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sat_r  <= v_nxt > 58'(crs_pkg::OUT_MAX);
      out_rate_r <= (v_nxt > 58'(crs_pkg::OUT_MAX)) ? crs_pkg::OUT_MAX : v_nxt[23:0];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.rate_value = out_rate_r;
  assign out_chan.saturated  = out_sat_r;

endmodule

[rtl/core/crs_divider.sv]
// ----------------------------------------------------------------------------
// crs_divider: pipelined restoring divider
// One quotient bit per stage, 48 stages; the dividend's upper 16 bits must
// be below the divisor. A sideband record rides along with each request.
// ----------------------------------------------------------------------------
module crs_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_dividend,
  input  logic [33:0]       in_divisor,
  input  crs_pkg::side_t    in_side,
  output logic              out_valid,
  output logic [47:0]       out_quot,
  output crs_pkg::side_t    out_side
);

  localparam int unsigned QW = crs_pkg::DIV_QW;

  logic           v_r    [QW];
  logic [33:0]    rem_r  [QW];
  logic [47:0]    low_r  [QW];
  logic [47:0]    quot_r [QW];
  logic [33:0]    dvs_r  [QW];
  crs_pkg::side_t side_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic           pv;
    logic [33:0]    prem;
    logic [33:0]    pdvs;
    logic [47:0]    plow;
    logic [47:0]    pquot;
    crs_pkg::side_t pside;
    logic [34:0]    trial;
    logic [34:0]    diff;
    logic           take;

    // previous stage or request input
    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = {18'b0, in_dividend[63:48]};
      assign plow  = in_dividend[47:0];
      assign pquot = '0;
      assign pdvs  = in_divisor;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[g-1];
      assign prem  = rem_r[g-1];
      assign plow  = low_r[g-1];
      assign pquot = quot_r[g-1];
      assign pdvs  = dvs_r[g-1];
      assign pside = side_r[g-1];
    end

    // one trial subtraction
    assign trial = {prem, plow[QW-1-g]};
    assign diff  = trial - {1'b0, pdvs};
    assign take  = trial >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? diff[33:0] : trial[33:0];
        low_r[g]  <= plow;
        quot_r[g] <= {pquot[46:0], take};
        dvs_r[g]  <= pdvs;
        side_r[g] <= pside;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

[rtl/core/crs_expneg.sv]
// ----------------------------------------------------------------------------
// crs_expneg: pipelined e^-y series
// Twelve series terms for y in UQ0.32, three stages per term: product with
// y, reciprocal multiply, then quotient correction and accumulate.
// ----------------------------------------------------------------------------
module crs_expneg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       in_arg,
  input  crs_pkg::side_t    in_side,
  output logic              out_valid,
  output logic [32:0]       out_val,
  output crs_pkg::side_t    out_side
);

  localparam int unsigned NT = crs_pkg::EXP_TERMS;

  logic           a_v_r    [NT];
  logic [31:0]    a_t_r    [NT];
  logic [32:0]    a_sum_r  [NT];
  logic [31:0]    a_y_r    [NT];
  crs_pkg::side_t a_side_r [NT];
  logic           b_v_r    [NT];
  logic [31:0]    b_q0_r   [NT];
  logic [31:0]    b_t_r    [NT];
  logic [32:0]    b_sum_r  [NT];
  logic [31:0]    b_y_r    [NT];
  crs_pkg::side_t b_side_r [NT];
  logic           c_v_r    [NT];
  logic [32:0]    c_term_r [NT];
  logic [32:0]    c_sum_r  [NT];
  logic [31:0]    c_y_r    [NT];
  crs_pkg::side_t c_side_r [NT];

  for (genvar g = 0; g < NT; g++) begin : g_term
    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / (g + 1));
    localparam logic [3:0]  DIVR  = 4'(g + 1);

    logic           pv;
    logic [32:0]    pterm;
    logic [32:0]    psum;
    logic [31:0]    py;
    crs_pkg::side_t pside;
    logic [64:0]    prod;
    logic [64:0]    qm;
    logic [35:0]    qi;
    logic [35:0]    rr;
    logic [31:0]    q;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign pterm = crs_pkg::ONE_Q32;
      assign psum  = crs_pkg::ONE_Q32;
      assign py    = in_arg;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = c_v_r[g-1];
      assign pterm = c_term_r[g-1];
      assign psum  = c_sum_r[g-1];
      assign py    = c_y_r[g-1];
      assign pside = c_side_r[g-1];
    end

    // previous term times y
    assign prod = 65'(pterm) * 65'(py);
    // divide by the term index through its reciprocal
    assign qm   = 65'(a_t_r[g]) * 65'(RECIP);
    // the estimate is at most one low
    assign qi   = 36'(b_q0_r[g]) * 36'(DIVR);
    assign rr   = 36'(b_t_r[g]) - qi;
    assign q    = (rr >= 36'(DIVR)) ? b_q0_r[g] + 32'd1 : b_q0_r[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r[g] <= 1'b0;
        b_v_r[g] <= 1'b0;
        c_v_r[g] <= 1'b0;
      end else if (en) begin
        a_v_r[g] <= pv;
        b_v_r[g] <= a_v_r[g];
        c_v_r[g] <= b_v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_t_r[g]    <= prod[63:32];
        a_sum_r[g]  <= psum;
        a_y_r[g]    <= py;
        a_side_r[g] <= pside;
        b_q0_r[g]   <= qm[63:32];
        b_t_r[g]    <= a_t_r[g];
        b_sum_r[g]  <= a_sum_r[g];
        b_y_r[g]    <= a_y_r[g];
        b_side_r[g] <= a_side_r[g];
        c_term_r[g] <= {1'b0, q};
        // odd terms subtract, even terms add
        c_sum_r[g]  <= (g % 2 == 0) ? b_sum_r[g] - {1'b0, q} : b_sum_r[g] + {1'b0, q};
        c_y_r[g]    <= b_y_r[g];
        c_side_r[g] <= b_side_r[g];
      end
    end
  end

  assign out_valid = c_v_r[NT-1];
  assign out_val   = c_sum_r[NT-1];
  assign out_side  = c_side_r[NT-1];

endmodule

[tb/click_rate_smoothing_unit_tb.sv]
// ----------------------------------------------------------------------------
// click_rate_smoothing_unit_tb: self-checking bench for the click rate unit
// Feeds counter requests over the input channel with random idle gaps and
// output stalls, predicts each smoothed rate in fixed point and compares
// every returned result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module click_rate_smoothing_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]   shows;
    logic [31:0]   clicks;
    crs_pkg::op_t  op;
  } crs_req_t;

  typedef struct {
    logic [23:0] rate;
    logic        sat;
  } crs_rate_t;

  localparam longint unsigned Q32 = 64'h1_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crs_in_if  in_if ();
  crs_out_if out_if ();

  click_rate_smoothing_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  crs_req_t  req_queue[$];
  crs_rate_t rate_queue[$];
  crs_req_t  offered_req;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      long_hold = 1'b0;
  int        hold_left = 0;
  int        errors = 0;
  int        n_accepted = 0;
  int        n_checked = 0;
  int        n_saturated = 0;
  int        op_seen[4] = '{0, 0, 0, 0};

  // clock, period 8 ns
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // e^-y series, y in UQ0.32
  function automatic longint unsigned exp_series(longint unsigned y);
    longint unsigned sum;
    longint unsigned term;
    sum = Q32;
    term = Q32;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * y) >> 32) / i;
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // confidence weight 2/(1+e^-shows)-1, UQ1.16
  function automatic longint unsigned confidence_weight(longint unsigned s);
    longint unsigned e;
    if (s >= 6144) return 65536;
    e = exp_series(s << 19);
    for (int k = 0; k < 5; k++) begin
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      e = (e * e) >> 32;
    end
    return ((Q32 - e) << 16) / (Q32 + e);
  endfunction

  // 2^-a for a in UQ.8, result UQ1.32
  function automatic longint unsigned half_power(longint unsigned a);
    longint unsigned n;
    longint unsigned g;
    n = a >> 8;
    g = a & 255;
    if (n >= 32) return 0;
    return exp_series((g * 64'd2977044472) >> 8) >> n;
  endfunction

  // min(c,s)/s damped by 1/(1+2^(10-min)), UQ.16
  function automatic longint unsigned damped_ratio(longint unsigned s, longint unsigned c);
    longint unsigned m;
    longint unsigned frac;
    longint unsigned p;
    longint unsigned f;
    if (s == 0 || c == 0) return 0;
    m = (c < s) ? c : s;
    frac = (m << 16) / s;
    if (m <= 2560) begin
      p = half_power(2560 - m);
      f = (p << 30) / (p + Q32);
    end else begin
      p = half_power(m - 2560);
      f = (64'd1 << 62) / (Q32 + p);
    end
    return (frac * f) >> 30;
  endfunction

  // expected rate for one request
  function automatic crs_rate_t rate_predict(crs_req_t q);
    longint unsigned s;
    longint unsigned c;
    longint unsigned r;
    longint unsigned w;
    longint unsigned v;
    longint unsigned rc;
    crs_rate_t res;
    s = q.shows;
    c = q.clicks;
    r = (s == 0) ? 0 : (c << 16) / s;
    case (q.op)
      crs_pkg::OP_PLAIN: v = r;
      crs_pkg::OP_CONF: begin
        w = confidence_weight(s);
        v = (65536 - w + r) >> 1;
      end
      crs_pkg::OP_DAMPED: v = damped_ratio(s, c);
      default: begin
        w = confidence_weight(s);
        rc = (r > (64'd1 << 40)) ? (64'd1 << 40) : r;
        v = (((65536 - w) << 15) + rc * w) >> 16;
      end
    endcase
    if (v > 64'hFF_FFFF) begin
      res.rate = 24'hFF_FFFF;
      res.sat = 1'b1;
    end else begin
      res.rate = v[23:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // counter value biased toward the interesting regions
  function automatic logic [31:0] pick_count(logic [31:0] other);
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return $urandom_range(0, 6200);
      2: return $urandom_range(2300, 2800);
      3: return 32'd0;
      4: return (other == 0) ? 32'd0 : $urandom_range(0, other);
      5: return $urandom_range(0, 1 << 20);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic crs_req_t make_req(logic [31:0] s, logic [31:0] c, crs_pkg::op_t op);
    crs_req_t q;
    q.shows = s;
    q.clicks = c;
    q.op = op;
    return q;
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rate_queue.push_back(rate_predict(offered_req));
        n_accepted++;
        op_seen[offered_req.op]++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_req = req_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.shows_count <= offered_req.shows;
          in_if.clicks_count <= offered_req.clicks;
          in_if.opcode <= offered_req.op;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted down in its own process
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      long_hold <= 1'b1;
    end else begin
      long_hold <= 1'b0;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : watch
    crs_rate_t exp_rate;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (rate_queue.size() == 0) begin
          $error("result with no request pending: rate_value %h", out_if.rate_value);
          errors++;
        end else begin
          exp_rate = rate_queue.pop_front();
          n_checked++;
          if (exp_rate.sat) n_saturated++;
          if (out_if.rate_value !== exp_rate.rate) begin
            $error("rate_value expected %h actual %h", exp_rate.rate, out_if.rate_value);
            errors++;
          end
          if (out_if.saturated !== exp_rate.sat) begin
            $error("saturated expected %b actual %b", exp_rate.sat, out_if.saturated);
            errors++;
          end
        end
      end
      out_if.ready <= !long_hold && !(hold_left > 0) &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // timeout
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    logic [31:0] s;
    logic [31:0] c;
    idle_tab = '{0, 66, 0, 22};
    stall_tab = '{0, 0, 66, 22};
    in_if.valid = 1'b0;
    in_if.shows_count = '0;
    in_if.clicks_count = '0;
    in_if.opcode = crs_pkg::OP_PLAIN;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, every opcode
    for (int o = 0; o < 4; o++) begin
      req_queue.push_back(make_req(32'd0, 32'hFFFF_FFFF, crs_pkg::op_t'(o)));
      req_queue.push_back(make_req(32'hFFFF_FFFF, 32'd0, crs_pkg::op_t'(o)));
      req_queue.push_back(make_req(32'd1, 32'hFFFF_FFFF, crs_pkg::op_t'(o)));
      req_queue.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, crs_pkg::op_t'(o)));
    end
    req_queue.push_back(make_req(32'd2560, 32'd2560, crs_pkg::OP_DAMPED));
    req_queue.push_back(make_req(32'd2561, 32'd5000, crs_pkg::OP_DAMPED));
    req_queue.push_back(make_req(32'd6143, 32'd100, crs_pkg::OP_CONF));
    req_queue.push_back(make_req(32'd6144, 32'd100, crs_pkg::OP_BLEND));
    req_queue.push_back(make_req(32'd0, 32'd0, crs_pkg::OP_BLEND));
    req_queue.push_back(make_req(32'd256, 32'd256, crs_pkg::OP_PLAIN));
    wait (req_queue.size() == 0);

    // random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      send_idle_pct <= idle_tab[p];
      recv_stall_pct <= stall_tab[p];
      for (int i = 0; i < 355; i++) begin
        s = pick_count(32'hFFFF_FFFF);
        c = pick_count(s);
        req_queue.push_back(make_req(s, c, crs_pkg::op_t'($urandom_range(0, 3))));
      end
      // stall the output long enough to back the pipeline up
      if (p == 0) begin
        @(posedge clk);
        hold_left <= 400;
      end
      wait (req_queue.size() == 0);
      // sender pause until everything has drained
      wait (rate_queue.size() == 0 && !in_if.valid);
    end

    @(posedge clk);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    wait (rate_queue.size() == 0 && !in_if.valid);
    repeat (300) @(posedge clk);
    $display("covered %0d requests (plain %0d, conf %0d, damped %0d, blend %0d)",
             n_accepted, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("checked %0d results, %0d saturated, under idle, stall and backpressure",
             n_checked, n_saturated);
    if (errors == 0 && rate_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[click_rate_smoothing_unit.f]
rtl/core/crs_pkg.sv
rtl/core/crs_if.sv
rtl/core/crs_divider.sv
rtl/core/crs_expneg.sv
rtl/core/click_rate_smoothing_unit.sv
tb/click_rate_smoothing_unit_tb.sv
